/* rtl/core/tdim_pkg.sv */
// ----------------------------------------------------------------------------
// tdim_pkg
// Shared constants for the touch dimmer: register map, reset values, widths.
// ----------------------------------------------------------------------------
package tdim_pkg;

  localparam int DUTY_W    = 8;
  localparam int LOCK_W    = 16;
  localparam int SINCE_W   = 16;
  localparam int ON_W      = 24;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_MAX_DUTY    = 5'd0;
  localparam logic [PADDR_W-1:0] ADDR_LOCK_TICKS  = 5'd4;
  localparam logic [PADDR_W-1:0] ADDR_TURNOFF     = 5'd8;
  localparam logic [PADDR_W-1:0] ADDR_ON_TIMEOUT  = 5'd12;
  localparam logic [PADDR_W-1:0] ADDR_MAX_TIMEOUT = 5'd16;

  // reset values
  localparam logic [DUTY_W-1:0]  RST_MAX_DUTY    = 8'd110;
  localparam logic [LOCK_W-1:0]  RST_LOCK_TICKS  = 16'd31;
  localparam logic [LOCK_W-1:0]  RST_TURNOFF     = 16'd62;
  localparam logic [ON_W-1:0]    RST_ON_TIMEOUT  = 24'd55800;
  localparam logic [ON_W-1:0]    RST_MAX_TIMEOUT = 24'd1116000;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

  // step shift: brightness steps by duty/8
  localparam int STEP_SHIFT = 3;

endpackage

/* rtl/core/tdim_tick_if.sv */
// ----------------------------------------------------------------------------
// tdim_tick_if
// Tick channel: one sampled touch bit per transaction.
// ----------------------------------------------------------------------------
interface tdim_tick_if;
  logic valid;
  logic ready;
  logic touch;

  modport source (output valid, output touch, input ready);
  modport sink   (input valid, input touch, output ready);
endinterface

/* rtl/core/tdim_result_if.sv */
// ----------------------------------------------------------------------------
// tdim_result_if
// Result channel: lamp state after one tick.
// ----------------------------------------------------------------------------
interface tdim_result_if
  import tdim_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;
  logic              drive_enabled;
  logic              max_notify;
  logic              is_timed_out;

  modport source (output valid, output duty, output drive_enabled, output max_notify,
                  output is_timed_out, input ready);
  modport sink   (input valid, input duty, input drive_enabled, input max_notify,
                  input is_timed_out, output ready);
endinterface

/* rtl/core/touch_dimmer_with_auto_off_top.sv */
// ----------------------------------------------------------------------------
// touch_dimmer_with_auto_off_top
// Touch dimmer lamp with lockout, turn-off on late touch and auto-off fade.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per tick, carrying the sampled touch bit.
//   result : one transaction per tick: duty, drive_enabled, max_notify,
//            is_timed_out, all as they stand after that tick.
//   APB    : five registers at byte addresses 0,4,8,12,16 (max_duty,
//            lock_ticks, turnoff_ticks, on_timeout_ticks, max_timeout_ticks).
//            Write only while no tick is in flight; reads return the value.
// Output: a tick's result is registered and shown in the next cycle.
// Throughput: one tick per cycle unless stalled; lamp update is a single pass of
//   compare/add logic from the state registers into the result register.
// Stall: the result register holds while result.ready is low; tick.ready
//   stays high as long as the result register is empty or being drained, so
//   a new tick is taken in the same cycle the pending result leaves.
// Reset: registers return to defaults, duty 0, direction up, drive enabled,
//   all counters zero, result register empty.
// ----------------------------------------------------------------------------
module touch_dimmer_with_auto_off_top
  import tdim_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  tdim_tick_if.sink           tick,
  tdim_result_if.source       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration
  logic [DUTY_W-1:0] max_duty;
  logic [LOCK_W-1:0] lock_ticks;
  logic [LOCK_W-1:0] turnoff_ticks;
  logic [ON_W-1:0]   on_timeout_ticks;
  logic [ON_W-1:0]   max_timeout_ticks;

  // lamp state
  logic [DUTY_W-1:0]  duty_level,     duty_level_next;
  logic               direction_up,   direction_up_next;
  logic               drive_on,       drive_on_next;
  logic [LOCK_W-1:0]  lock_count,     lock_count_next;
  logic [ON_W-1:0]    on_count,       on_count_next;
  logic               timed_out_flag, timed_out_flag_next;
  logic [SINCE_W-1:0] since_command,  since_command_next;
  logic               notify_next;

  // result register
  logic               res_valid;
  logic [DUTY_W-1:0]  res_duty;
  logic               res_drive;
  logic               res_notify;
  logic               res_timed_out;

  logic tick_accept;
  logic cfg_write;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign tick.ready  = !res_valid || result.ready;
  assign tick_accept = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty          <= RST_MAX_DUTY;
      lock_ticks        <= RST_LOCK_TICKS;
      turnoff_ticks     <= RST_TURNOFF;
      on_timeout_ticks  <= RST_ON_TIMEOUT;
      max_timeout_ticks <= RST_MAX_TIMEOUT;
    end else if (cfg_write) begin
      unique case (paddr)
        ADDR_MAX_DUTY:    max_duty          <= pwdata[DUTY_W-1:0];
        ADDR_LOCK_TICKS:  lock_ticks        <= pwdata[LOCK_W-1:0];
        ADDR_TURNOFF:     turnoff_ticks     <= pwdata[LOCK_W-1:0];
        ADDR_ON_TIMEOUT:  on_timeout_ticks  <= pwdata[ON_W-1:0];
        ADDR_MAX_TIMEOUT: max_timeout_ticks <= pwdata[ON_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_MAX_DUTY:    prdata = {{(PDATA_W-DUTY_W){1'b0}}, max_duty};
      ADDR_LOCK_TICKS:  prdata = {{(PDATA_W-LOCK_W){1'b0}}, lock_ticks};
      ADDR_TURNOFF:     prdata = {{(PDATA_W-LOCK_W){1'b0}}, turnoff_ticks};
      ADDR_ON_TIMEOUT:  prdata = {{(PDATA_W-ON_W){1'b0}}, on_timeout_ticks};
      ADDR_MAX_TIMEOUT: prdata = {{(PDATA_W-ON_W){1'b0}}, max_timeout_ticks};
      default:          prdata = '0;
    endcase
  end

  // step arithmetic
  logic [DUTY_W-1:0] step_diff;
  logic [DUTY_W:0]   step_up_sum;
  logic [DUTY_W-1:0] step_down_val;
  logic              hit_top;
  logic              hit_bottom;
  logic [DUTY_W-1:0] step_val;

  always_comb begin
    step_diff     = (duty_level >> STEP_SHIFT);
    if (step_diff == '0) begin
      step_diff = {{(DUTY_W-1){1'b0}}, 1'b1};
    end
    step_up_sum   = {1'b0, duty_level} + {1'b0, step_diff};
    step_down_val = duty_level - step_diff;
    if (direction_up) begin
      hit_bottom = 1'b0;
      hit_top    = step_up_sum > {1'b0, max_duty};
      step_val   = step_up_sum[DUTY_W-1:0];
    end else begin
      hit_bottom = step_diff > duty_level;
      hit_top    = !hit_bottom && (step_down_val > max_duty);
      step_val   = step_down_val;
    end
  end

  always_comb begin
    duty_level_next     = duty_level;
    direction_up_next   = direction_up;
    drive_on_next       = drive_on;
    lock_count_next     = lock_count;
    on_count_next       = on_count;
    timed_out_flag_next = timed_out_flag;
    notify_next         = 1'b0;
    since_command_next  = (since_command == SINCE_MAX) ? since_command
                                                       : since_command + 1'b1;

    if (lock_count != '0) begin
      lock_count_next = lock_count - 1'b1;
    end else if (tick.touch) begin
      timed_out_flag_next = 1'b0;
      if (since_command_next > turnoff_ticks && duty_level != '0) begin
        // late touch on a lit lamp: turn off
        duty_level_next     = '0;
        direction_up_next   = 1'b1;
        drive_on_next       = 1'b0;
        lock_count_next     = lock_ticks;
        timed_out_flag_next = 1'b1;
      end else begin
        if (hit_top) begin
          duty_level_next   = max_duty;
          direction_up_next = 1'b0;
          lock_count_next   = lock_ticks;
          drive_on_next     = 1'b1;
          notify_next       = 1'b1;
          on_count_next     = max_timeout_ticks;
        end else if (hit_bottom) begin
          duty_level_next   = '0;
          direction_up_next = 1'b1;
          drive_on_next     = 1'b0;
          lock_count_next   = lock_ticks;
          on_count_next     = on_timeout_ticks;
        end else begin
          duty_level_next   = step_val;
          drive_on_next     = 1'b1;
          on_count_next     = on_timeout_ticks;
        end
        since_command_next = '0;
      end
    end

    // on-timer and fade
    if (!timed_out_flag_next) begin
      if (on_count_next != '0) begin
        on_count_next = on_count_next - 1'b1;
      end else if (duty_level_next == '0) begin
        direction_up_next   = 1'b1;
        drive_on_next       = 1'b0;
        timed_out_flag_next = 1'b1;
      end else begin
        duty_level_next = duty_level_next - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level     <= '0;
      direction_up   <= 1'b1;
      drive_on       <= 1'b1;
      lock_count     <= '0;
      on_count       <= '0;
      timed_out_flag <= 1'b0;
      since_command  <= '0;
    end else if (tick_accept) begin
      duty_level     <= duty_level_next;
      direction_up   <= direction_up_next;
      drive_on       <= drive_on_next;
      lock_count     <= lock_count_next;
      on_count       <= on_count_next;
      timed_out_flag <= timed_out_flag_next;
      since_command  <= since_command_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tick_accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      res_duty      <= duty_level_next;
      res_drive     <= drive_on_next;
      res_notify    <= notify_next;
      res_timed_out <= timed_out_flag_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.duty          = res_duty;
  assign result.drive_enabled = res_drive;
  assign result.max_notify    = res_notify;
  assign result.is_timed_out  = res_timed_out;

  // a disabled drive always sits at zero duty
  a_off_is_dark: assert property (@(posedge clk) disable iff (rst)
    !drive_on |-> duty_level == '0)
    else $error("drive disabled with nonzero duty");

  // timed out implies dark and disabled
  a_timed_out_dark: assert property (@(posedge clk) disable iff (rst)
    timed_out_flag |-> (!drive_on && duty_level == '0))
    else $error("timed out with lamp lit");

  // lockout counts down by exactly one per accepted tick
  a_lock_countdown: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && lock_count != '0) |=> lock_count == $past(lock_count) - 1'b1)
    else $error("lockout did not count down");

  // a notify result never lies above the maximum (a zero reload fades it by one)
  a_notify_at_max: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_notify) |-> res_duty <= max_duty)
    else $error("max notify above maximum duty");

  // no tick taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |-> !tick.ready)
    else $error("tick accepted over a stalled result");

endmodule
